// File: src/las_pkg.sv
// ----------------------------------------------------------------------------
// las_pkg
// Shared types, codes and the B3/S23 cell rule for the life automaton step.
// ----------------------------------------------------------------------------
`default_nettype none

package las_pkg;

  // Request codes carried on req_type.
  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_code_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;

  // Register value after reset, before clamping to the grid size.
  localparam logic [6:0] DIM_RESET = 7'd64;

  // Neighbour counts of the rule.
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Control of the row window during a generation sweep.
  typedef struct packed {
    logic prime_mid;    // load the first row into the middle line
    logic prime_below;  // load the second row into the lower line
    logic rotate;       // evaluate one column and rotate the lines
    logic advance;      // move the window down by one row
    logic fetch_ok;     // the fetched row exists in the memory
    logic above_ok;     // upper row lies inside the grid in use
    logic mid_ok;       // middle row lies inside the grid in use
    logic below_ok;     // lower row lies inside the grid in use
    logic first_col;    // the current column is column zero
    logic cur_ok;       // the current column lies inside the grid in use
    logic next_ok;      // the column to the right lies inside the grid in use
  } win_ctrl_t;

  function automatic logic life_rule(input logic alive, input logic [3:0] count);
    return (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
  endfunction

endpackage

`default_nettype wire

// File: src/las_grid_mem.sv
// ----------------------------------------------------------------------------
// las_grid_mem
// Row-wide grid storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module las_grid_mem #(
  parameter int ROW_W  = 64,
  parameter int ADDR_W = 7
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [ROW_W-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [ROW_W-1:0]  wr_data
);

  logic [ROW_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/las_row_window.sv
// ----------------------------------------------------------------------------
// las_row_window
// Three-row window that evaluates one cell per cycle and builds the new row.
// ----------------------------------------------------------------------------
`default_nettype none

module las_row_window
  import las_pkg::*;
#(
  parameter int MAX_COLS = 64
) (
  input  wire logic                clk,
  input  wire win_ctrl_t           ctrl,
  input  wire logic [MAX_COLS-1:0] rd_data,
  output logic      [MAX_COLS-1:0] row_out
);

  logic [MAX_COLS-1:0] above;
  logic [MAX_COLS-1:0] mid;
  logic [MAX_COLS-1:0] below;
  logic                above_left;
  logic                mid_left;
  logic                below_left;

  logic       a_l, a_c, a_r;
  logic       m_l, m_c, m_r;
  logic       b_l, b_c, b_r;
  logic [3:0] count;
  logic       in_range;
  logic       new_cell;

  // Bit 0 of each line is the current column and bit 1 the column to its right.
  // Cells outside the grid in use are masked so that they count as dead.
  always_comb begin
    a_l = above_left & ~ctrl.first_col;
    m_l = mid_left & ~ctrl.first_col;
    b_l = below_left & ~ctrl.first_col;
    a_c = above[0] & ctrl.above_ok & ctrl.cur_ok;
    m_c = mid[0] & ctrl.mid_ok & ctrl.cur_ok;
    b_c = below[0] & ctrl.below_ok & ctrl.cur_ok;
    a_r = above[1] & ctrl.above_ok & ctrl.next_ok;
    m_r = mid[1] & ctrl.mid_ok & ctrl.next_ok;
    b_r = below[1] & ctrl.below_ok & ctrl.next_ok;
    count = 4'(a_l) + 4'(a_c) + 4'(a_r) + 4'(m_l) + 4'(m_r)
          + 4'(b_l) + 4'(b_c) + 4'(b_r);
    in_range = ctrl.mid_ok & ctrl.cur_ok;
    // Cells beyond the grid in use keep their stored value.
    new_cell = in_range ? life_rule(mid[0], count) : mid[0];
  end

  // A full sweep rotates each line MAX_COLS times, so the lines are intact
  // again when the window moves down.
  always_ff @(posedge clk) begin
    if (ctrl.prime_mid) begin
      above <= '0;
      mid   <= rd_data;
    end
    if (ctrl.prime_below) begin
      below <= rd_data;
    end
    if (ctrl.rotate) begin
      above      <= {above[0], above[MAX_COLS-1:1]};
      mid        <= {mid[0], mid[MAX_COLS-1:1]};
      below      <= {below[0], below[MAX_COLS-1:1]};
      above_left <= a_c;
      mid_left   <= m_c;
      below_left <= b_c;
      row_out    <= {new_cell, row_out[MAX_COLS-1:1]};
    end
    if (ctrl.advance) begin
      above <= mid;
      mid   <= below;
      below <= ctrl.fetch_ok ? rd_data : '0;
    end
  end

endmodule

`default_nettype wire

// File: src/life_automaton_step.sv
// ----------------------------------------------------------------------------
// life_automaton_step
// B3/S23 cellular automaton over a grid of up to MAX_ROWS x MAX_COLS cells.
// Requests arrive on req_valid/req_stall with req_type, row, col and
// cell_value; each transaction produces exactly one response on
// rsp_valid/rsp_stall carrying cell_alive and bad_coordinate. The grid size
// in use is set through the cfg_valid/cfg_ready write port (index 0 rows,
// index 1 columns). The user is to write it only while the block is idle;
// the block itself does not enforce this. A cell write or read passes
// through ST_CELL before its response is registered; a request with a bad
// coordinate or an unused code registers its response in the cycle after
// acceptance. In a generation step, after ST_PRIME_MID and ST_PRIME_BELOW,
// one cell is evaluated per cycle in the row window and each row is then
// written back in ST_ROW_WR through the single write port. One request is
// in flight at a time. After reset the grid is cleared one row per cycle,
// and no request is accepted until that pass ends. A response held by rsp_stall
// stays in the output register; a new request is accepted in the cycle the
// response leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module life_automaton_step
  import las_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] req_type,
  input  wire logic [5:0] row,
  input  wire logic [5:0] col,
  input  wire logic       cell_value,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic            cell_alive,
  output logic            bad_coordinate,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [6:0] cfg_data
);

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int RDW = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
  localparam int CDW = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
  localparam logic [RW-1:0]  LAST_ROW = RW'(MAX_ROWS - 1);
  localparam logic [CIW-1:0] LAST_COL = CIW'(MAX_COLS - 1);
  localparam logic [RW:0]    ROW_LIM  = (RW + 1)'(MAX_ROWS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_PRIME_MID,
    ST_PRIME_BELOW,
    ST_SWEEP,
    ST_ROW_WR
  } state_t;

  function automatic logic [RDW-1:0] clamp_rows(input logic [6:0] v);
    if (v == 7'd0) begin
      return RDW'(1);
    end else if (RDW'(v) > RDW'(MAX_ROWS)) begin
      return RDW'(MAX_ROWS);
    end
    return RDW'(v);
  endfunction

  function automatic logic [CDW-1:0] clamp_cols(input logic [6:0] v);
    if (v == 7'd0) begin
      return CDW'(1);
    end else if (CDW'(v) > CDW'(MAX_COLS)) begin
      return CDW'(MAX_COLS);
    end
    return CDW'(v);
  endfunction

  state_t          state;
  logic [RW-1:0]   r;
  logic [CIW-1:0]  c;
  logic            bank;
  logic [RDW-1:0]  rows_eff;
  logic [CDW-1:0]  cols_eff;
  logic [RW-1:0]   row_q;
  logic [CIW-1:0]  col_q;
  logic            value_q;
  logic            write_q;

  logic                req_fire;
  logic                cfg_fire;
  logic                coord_ok;
  logic                rd_en;
  logic [RW:0]         rd_addr;
  logic [MAX_COLS-1:0] rd_data;
  logic                wr_en;
  logic [RW:0]         wr_addr;
  logic [MAX_COLS-1:0] wr_data;
  logic [MAX_COLS-1:0] cell_row;
  logic [MAX_COLS-1:0] row_out;
  logic [RW:0]         r_plus2;
  win_ctrl_t           ctrl;

  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign req_fire  = req_valid && !req_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign coord_ok  = (RDW'(row) < rows_eff) && (CDW'(col) < cols_eff);
  assign r_plus2   = {1'b0, r} + (RW + 1)'(2);

  always_comb begin
    cell_row        = rd_data;
    cell_row[col_q] = value_q;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {bank, RW'(row)};
    wr_en   = 1'b0;
    wr_addr = {bank, r};
    wr_data = '0;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = {1'b0, r};
      end
      ST_IDLE: begin
        rd_en   = 1'b1;
        rd_addr = (req_type == REQ_STEP) ? {bank, {RW{1'b0}}} : {bank, RW'(row)};
      end
      ST_CELL: begin
        wr_en   = write_q;
        wr_addr = {bank, row_q};
        wr_data = cell_row;
      end
      ST_PRIME_MID: begin
        rd_en   = 1'b1;
        rd_addr = {bank, RW'(1)};
      end
      ST_PRIME_BELOW: begin
      end
      ST_SWEEP: begin
        // Fetch the row two below during the last column of this row.
        rd_en   = (c == LAST_COL) && (r_plus2 < ROW_LIM);
        rd_addr = {bank, r_plus2[RW-1:0]};
      end
      ST_ROW_WR: begin
        wr_en   = 1'b1;
        wr_addr = {~bank, r};
        wr_data = row_out;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.prime_mid   = (state == ST_PRIME_MID);
    ctrl.prime_below = (state == ST_PRIME_BELOW);
    ctrl.rotate      = (state == ST_SWEEP);
    ctrl.advance     = (state == ST_ROW_WR);
    ctrl.fetch_ok    = (r_plus2 < ROW_LIM);
    ctrl.above_ok    = (r != '0) && (RDW'(r) <= rows_eff);
    ctrl.mid_ok      = (RDW'(r) < rows_eff);
    ctrl.below_ok    = ((RDW'(r) + RDW'(1)) < rows_eff);
    ctrl.first_col   = (c == '0);
    ctrl.cur_ok      = (CDW'(c) < cols_eff);
    ctrl.next_ok     = ((CDW'(c) + CDW'(1)) < cols_eff);
  end

  las_grid_mem #(
    .ROW_W  (MAX_COLS),
    .ADDR_W (RW + 1)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  las_row_window #(
    .MAX_COLS (MAX_COLS)
  ) u_window (
    .clk     (clk),
    .ctrl    (ctrl),
    .rd_data (rd_data),
    .row_out (row_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      r         <= '0;
      c         <= '0;
      bank      <= 1'b0;
      rsp_valid <= 1'b0;
      rows_eff  <= clamp_rows(DIM_RESET);
      cols_eff  <= clamp_cols(DIM_RESET);
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_fire) begin
        if (cfg_index == CFG_ROWS) begin
          rows_eff <= clamp_rows(cfg_data);
        end else if (cfg_index == CFG_COLS) begin
          cols_eff <= clamp_cols(cfg_data);
        end
      end
      unique case (state)
        ST_CLEAR: begin
          r <= r + RW'(1);
          if (r == LAST_ROW) begin
            r     <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            priority if (req_type == REQ_WRITE || req_type == REQ_READ) begin
              row_q   <= RW'(row);
              col_q   <= CIW'(col);
              value_q <= cell_value;
              write_q <= (req_type == REQ_WRITE);
              if (coord_ok) begin
                state <= ST_CELL;
              end else begin
                rsp_valid      <= 1'b1;
                cell_alive     <= 1'b0;
                bad_coordinate <= 1'b1;
              end
            end else if (req_type == REQ_STEP) begin
              r     <= '0;
              c     <= '0;
              state <= ST_PRIME_MID;
            end else begin
              rsp_valid      <= 1'b1;
              cell_alive     <= 1'b0;
              bad_coordinate <= 1'b0;
            end
          end
        end
        ST_CELL: begin
          rsp_valid      <= 1'b1;
          cell_alive     <= ~write_q & rd_data[col_q];
          bad_coordinate <= 1'b0;
          state          <= ST_IDLE;
        end
        ST_PRIME_MID: begin
          state <= ST_PRIME_BELOW;
        end
        ST_PRIME_BELOW: begin
          state <= ST_SWEEP;
        end
        ST_SWEEP: begin
          c <= c + CIW'(1);
          if (c == LAST_COL) begin
            c     <= '0;
            state <= ST_ROW_WR;
          end
        end
        ST_ROW_WR: begin
          if (r == LAST_ROW) begin
            // The new generation is complete in the other bank.
            bank           <= ~bank;
            r              <= '0;
            rsp_valid      <= 1'b1;
            cell_alive     <= 1'b0;
            bad_coordinate <= 1'b0;
            state          <= ST_IDLE;
          end else begin
            r     <= r + RW'(1);
            state <= ST_SWEEP;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An accepted request either answers at once or starts work.
  a_req_progress: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (rsp_valid || state != ST_IDLE))
    else $error("accepted request produced neither a response nor work");

  // Generation write-back never touches the bank being read.
  a_wb_bank: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROW_WR) |-> (wr_addr[RW] != bank))
    else $error("row write-back targets the current generation");

  // A rejected coordinate never reports a live cell.
  a_bad_dead: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && bad_coordinate) |-> !cell_alive)
    else $error("bad coordinate response carries a live cell");

  // The bank only flips as a step response is issued.
  a_flip_rsp: assert property (@(posedge clk) disable iff (rst)
    (bank != $past(bank)) |-> (rsp_valid && !bad_coordinate))
    else $error("bank flipped without a step response");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for life_automaton_step. It opens with a short table of
// requests and register writes, then runs phases of random cell writes,
// reads, unused codes and generation steps under changing grid sizes and
// handshake idling. A B3/S23 predictor gives each response the table lacks.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench
  import las_pkg::*;
();

  localparam int LIFE_ROWS = 64;
  localparam int LIFE_COLS = 64;

  // Register indexes beyond the list; writes to them must have no effect.
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    req_code_t  kind;
    logic [5:0] row_i;
    logic [5:0] col_i;
    logic       value;
  } cell_req_t;

  typedef struct packed {
    logic alive;
    logic bad;
  } cell_rsp_t;

  typedef struct packed {
    logic       is_cfg;
    logic [1:0] cfg_idx;
    logic [6:0] cfg_val;
    cell_req_t  req;
    logic       fixed;  // response is given in the row itself
    cell_rsp_t  rsp;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [1:0] req_type = REQ_NONE;
  logic [5:0] row = '0;
  logic [5:0] col = '0;
  logic       cell_value = 1'b0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic       cell_alive;
  logic       bad_coordinate;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_ROWS;
  logic [6:0] cfg_data = '0;

  // Predictor state.
  bit         life_now [LIFE_ROWS][LIFE_COLS];
  logic [6:0] rows_reg = DIM_RESET;
  logic [6:0] cols_reg = DIM_RESET;

  cell_rsp_t   pending_outcomes[$];
  script_row_t script[$];
  cell_rsp_t   want;
  int unsigned mismatches = 0;
  int unsigned rsp_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  life_automaton_step #(
    .MAX_ROWS(LIFE_ROWS),
    .MAX_COLS(LIFE_COLS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_type(req_type),
    .row(row),
    .col(col),
    .cell_value(cell_value),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .cell_alive(cell_alive),
    .bad_coordinate(bad_coordinate),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("life_automaton_step regression: fail");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: response %0d: %s", $time, rsp_count, msg);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int clip_size(input logic [6:0] raw, input int lim);
    if (raw == 0) return 1;
    if (raw > lim) return lim;
    return raw;
  endfunction

  function automatic int live_around(input int r, input int c, input int nr, input int nc);
    int n = 0;
    for (int dr = -1; dr <= 1; dr++)
      for (int dc = -1; dc <= 1; dc++)
        if ((dr != 0 || dc != 0) && r + dr >= 0 && c + dc >= 0 &&
            r + dr < nr && c + dc < nc)
          n += life_now[r + dr][c + dc];
    return n;
  endfunction

  // Cells outside the grid in use are neither evaluated nor overwritten.
  function automatic void advance_life();
    bit nxt [LIFE_ROWS][LIFE_COLS];
    int nr;
    int nc;
    int n;
    nr = clip_size(rows_reg, LIFE_ROWS);
    nc = clip_size(cols_reg, LIFE_COLS);
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++) begin
        n = live_around(r, c, nr, nc);
        nxt[r][c] = (n == 3) || (life_now[r][c] && n == 2);
      end
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        life_now[r][c] = nxt[r][c];
  endfunction

  function automatic cell_rsp_t predict_outcome(input cell_req_t q);
    cell_rsp_t o;
    o = '0;
    case (q.kind)
      REQ_WRITE, REQ_READ: begin
        if (q.row_i >= clip_size(rows_reg, LIFE_ROWS) ||
            q.col_i >= clip_size(cols_reg, LIFE_COLS)) begin
          o.bad = 1'b1;
        end else if (q.kind == REQ_WRITE) begin
          life_now[q.row_i][q.col_i] = q.value;
        end else begin
          o.alive = life_now[q.row_i][q.col_i];
        end
      end
      REQ_STEP: advance_life();
      default: ;
    endcase
    return o;
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_count++;
      if (pending_outcomes.size() == 0) begin
        note_mismatch("response with no request outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        if (cell_alive !== want.alive)
          note_mismatch($sformatf("cell_alive %b, expected %b", cell_alive, want.alive));
        if (bad_coordinate !== want.bad)
          note_mismatch($sformatf("bad_coordinate %b, expected %b",
                                  bad_coordinate, want.bad));
      end
    end
    rsp_stall <= ($urandom_range(99, 0) < stall_pct);
  end

  // ----------------------------------------------------------------- stimulus

  task automatic issue(input cell_req_t q, input logic fixed, input cell_rsp_t known);
    int unsigned gap = 0;
    cell_rsp_t pred;
    while ($urandom_range(99, 0) < send_idle_pct) gap++;
    if (gap != 0) begin
      req_valid <= 1'b0;
      req_type <= 2'($urandom_range(3, 0));
      row <= 6'($urandom_range(63, 0));
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= q.kind;
    row <= q.row_i;
    col <= q.col_i;
    cell_value <= q.value;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pred = predict_outcome(q);
    pending_outcomes.push_back(fixed ? known : pred);
  endtask

  // Holds off new requests until the block has answered everything.
  task automatic settle();
    req_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROWS) rows_reg = val;
    else if (idx == CFG_COLS) cols_reg = val;
    @(posedge clk);
  endtask

  function automatic script_row_t ask(input req_code_t k, input int r, input int c,
                                      input bit v);
    script_row_t s;
    s = '0;
    s.req = '{kind: k, row_i: 6'(r), col_i: 6'(c), value: v};
    return s;
  endfunction

  function automatic script_row_t ask_known(input req_code_t k, input int r, input int c,
                                            input bit v, input bit alive, input bit bad);
    script_row_t s;
    s = ask(k, r, c, v);
    s.fixed = 1'b1;
    s.rsp = '{alive: alive, bad: bad};
    return s;
  endfunction

  function automatic script_row_t set_reg(input logic [1:0] idx, input int val);
    script_row_t s;
    s = ask(REQ_NONE, 0, 0, 0);
    s.is_cfg = 1'b1;
    s.cfg_idx = idx;
    s.cfg_val = 7'(val);
    return s;
  endfunction

  // Raw register value: mostly a small grid, now and then zero or 64 to 127.
  function automatic logic [6:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) return 7'd0;
    if (sel == 1) return 7'($urandom_range(127, 64));
    return 7'($urandom_range(8, 2));
  endfunction

  // On a large grid, activity is kept near the borders so patterns form.
  function automatic logic [5:0] pick_coord(input int lim);
    if (lim <= 8) return 6'($urandom_range(lim - 1, 0));
    if ($urandom_range(1, 0) == 1) return 6'($urandom_range(3, 0));
    return 6'($urandom_range(lim - 1, lim - 4));
  endfunction

  task automatic random_phase(input int n_items, input logic [6:0] nrows_raw,
                              input logic [6:0] ncols_raw, input int unsigned idle_p,
                              input int unsigned stall_p);
    cell_req_t q;
    int unsigned sel;
    int nr;
    int nc;
    settle();
    write_reg(CFG_ROWS, nrows_raw);
    write_reg(CFG_COLS, ncols_raw);
    send_idle_pct = idle_p;
    stall_pct = stall_p;
    nr = clip_size(rows_reg, LIFE_ROWS);
    nc = clip_size(cols_reg, LIFE_COLS);
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(99, 0);
      q.row_i = pick_coord(nr);
      q.col_i = pick_coord(nc);
      q.value = ($urandom_range(99, 0) < 45);
      if (sel < 45) begin
        q.kind = REQ_WRITE;
      end else if (sel < 75) begin
        q.kind = REQ_READ;
      end else if (sel < 86) begin
        q.kind = REQ_STEP;
      end else if (sel < 90) begin
        q.kind = REQ_NONE;
        q.row_i = 6'($urandom_range(63, 0));
        q.col_i = 6'($urandom_range(63, 0));
      end else begin
        q.kind = $urandom_range(1, 0) ? REQ_READ : REQ_WRITE;
        if (nr < LIFE_ROWS && (nc == LIFE_COLS || $urandom_range(1, 0) == 1)) begin
          q.row_i = 6'($urandom_range(LIFE_ROWS - 1, nr));
          q.col_i = 6'($urandom_range(63, 0));
        end else if (nc < LIFE_COLS) begin
          q.row_i = 6'($urandom_range(63, 0));
          q.col_i = 6'($urandom_range(LIFE_COLS - 1, nc));
        end
      end
      issue(q, 1'b0, '0);
    end
  endtask

  initial begin
    // Corner cells, a corner block that forms in one step, then a one-row
    // grid in which the block's lower half is kept but no longer counted.
    script.push_back(ask_known(REQ_READ, 0, 0, 0, 0, 0));
    script.push_back(ask_known(REQ_READ, 63, 63, 1, 0, 0));
    script.push_back(ask_known(REQ_WRITE, 0, 0, 1, 0, 0));
    script.push_back(ask_known(REQ_WRITE, 63, 63, 1, 0, 0));
    script.push_back(ask(REQ_READ, 0, 0, 0));
    script.push_back(ask(REQ_READ, 63, 63, 0));
    script.push_back(ask_known(REQ_NONE, 63, 63, 1, 0, 0));
    script.push_back(ask(REQ_WRITE, 0, 1, 1));
    script.push_back(ask(REQ_WRITE, 1, 0, 1));
    script.push_back(ask_known(REQ_STEP, 0, 0, 0, 0, 0));
    script.push_back(ask(REQ_READ, 1, 1, 0));
    script.push_back(ask(REQ_READ, 63, 63, 0));
    script.push_back(set_reg(CFG_ROWS, 0));
    script.push_back(set_reg(CFG_COLS, 127));
    script.push_back(ask_known(REQ_READ, 1, 0, 0, 0, 1));
    script.push_back(ask_known(REQ_WRITE, 0, 63, 1, 0, 0));
    script.push_back(ask_known(REQ_STEP, 63, 63, 1, 0, 0));
    script.push_back(ask(REQ_READ, 0, 1, 0));
    script.push_back(set_reg(CFG_SPARE_LO, 5));
    script.push_back(set_reg(CFG_SPARE_HI, 0));
    script.push_back(set_reg(CFG_ROWS, 64));
    script.push_back(set_reg(CFG_COLS, 1));
    script.push_back(ask(REQ_READ, 1, 0, 0));
    script.push_back(ask(REQ_READ, 63, 0, 0));
    script.push_back(ask_known(REQ_READ, 0, 1, 0, 0, 1));
    script.push_back(ask_known(REQ_WRITE, 0, 63, 0, 0, 1));
    script.push_back(ask(REQ_READ, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        settle();
        write_reg(script[i].cfg_idx, script[i].cfg_val);
      end else begin
        issue(script[i].req, script[i].fixed, script[i].rsp);
      end
    end

    random_phase(23, 7'd127, 7'd64, 0, 0);
    random_phase(23, pick_dim(), pick_dim(), 72, 0);
    random_phase(23, pick_dim(), pick_dim(), 0, 72);
    random_phase(23, pick_dim(), pick_dim(), 38, 38);
    random_phase(23, pick_dim(), pick_dim(), 0, 0);

    req_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_outcomes.size() != 0)
      note_mismatch($sformatf("%0d responses never arrived", pending_outcomes.size()));

    if (mismatches == 0) begin
      $display("life_automaton_step regression: pass");
    end else begin
      $display("life_automaton_step regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/las_pkg.sv
src/las_grid_mem.sv
src/las_row_window.sv
src/life_automaton_step.sv
verif/testbench.sv
